FILE: design/hpms_pkg.sv
// package for the heat pump mode selector: item types, mode codes and lane masks
`default_nettype none
package hpms_pkg;

  localparam int NUM_THERMOSTATS = 4;
  localparam int NUM_FANCOILS    = 4;
  localparam int LANE_W          = 4;
  localparam int TIMER_W         = 20;
  localparam int DT_W            = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [LANE_W-1:0] TSTAT_MASK =
    LANE_W'((64'd1 << NUM_THERMOSTATS) - 64'd1);
  localparam logic [LANE_W-1:0] FCOIL_MASK =
    LANE_W'((64'd1 << NUM_FANCOILS) - 64'd1);

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam logic [TIMER_W-1:0] RST_H2C_LOCKOUT = TIMER_W'(21600);
  localparam logic [TIMER_W-1:0] RST_C2H_LOCKOUT = TIMER_W'(3600);
  localparam logic [TIMER_W-1:0] RST_STBY_DELAY  = TIMER_W'(3600);

  localparam logic [CFG_IDX_W-1:0] CFG_H2C_LOCKOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C2H_LOCKOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STBY_DELAY  = 2'd2;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_HEAT    = 2'd2,
    MODE_COOL    = 2'd3
  } mode_t;

  typedef struct packed {
    logic              system_on;
    logic [LANE_W-1:0] thermostat_w;
    logic [LANE_W-1:0] thermostat_y;
    logic [LANE_W-1:0] fancoil_valid;
    logic [LANE_W-1:0] fancoil_ob;
    logic [DT_W-1:0]   elapsed_seconds;
  } in_item_t;

  typedef struct packed {
    mode_t             pump_mode;
    logic [LANE_W-1:0] valve_targets;
    logic              zone_pump;
    logic              fancoil_pump;
  } out_item_t;

endpackage
`default_nettype wire

FILE: design/heat_pump_mode_selector_unit.sv
// top level of the heat pump mode selector
//
// input channel in_valid/in_ready/in_item carries one update item per accept;
// output channel out_valid/out_ready/out_item returns one result item for each.
// an accepted item sits in an input register, the decision logic runs on it
// and the result lands in the output register, which drives out_valid and
// out_item. one item per cycle is sustained while the receiver takes each
// result, set by the single pass of compare and saturating add logic that
// feeds the timer and mode registers.
// the timers and the previous mode update when an item moves into the output
// register, so items are processed strictly in order.
// when the receiver stalls, the output register holds its item and the input
// register still takes one more item; in_ready drops only when both are full.
// cfg_we writes one of the three 20-bit registers at cfg_index; index 3 is
// ignored. writes are meant for idle periods only.
// synchronous reset (rst_n low) empties both registers, loads the register
// defaults, saturates both timers and sets the previous mode to off.
`default_nettype none
module heat_pump_mode_selector_unit
  import hpms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIMER_W-1:0]   cfg_data
);

  logic [TIMER_W-1:0] h2c_lockout_r, c2h_lockout_r, stby_delay_r;
  logic [TIMER_W-1:0] since_heat_r, since_cool_r;
  logic [TIMER_W-1:0] since_heat_nxt, since_cool_nxt;
  mode_t              prev_mode_r, mode_nxt;
  logic               s1_valid_r, out_valid_r;
  in_item_t           s1_item_r;
  out_item_t          out_item_r, out_item_nxt;
  logic               advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2c_lockout_r <= RST_H2C_LOCKOUT;
      c2h_lockout_r <= RST_C2H_LOCKOUT;
      stby_delay_r  <= RST_STBY_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_H2C_LOCKOUT: h2c_lockout_r <= cfg_data;
        CFG_C2H_LOCKOUT: c2h_lockout_r <= cfg_data;
        CFG_STBY_DELAY:  stby_delay_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [LANE_W-1:0]  w, y, fv, fob;
    logic [LANE_W-1:0]  ts_heat, ts_cool, fc_heat, fc_cool;
    logic [TIMER_W:0]   sum_h, sum_c;
    logic [TIMER_W-1:0] sh, sc;
    logic               heat, cool, lock;
    mode_t              mode;

    w  = s1_item_r.thermostat_w & TSTAT_MASK;
    y  = s1_item_r.thermostat_y & TSTAT_MASK;
    fv = s1_item_r.fancoil_valid & FCOIL_MASK;
    fob = s1_item_r.fancoil_ob & FCOIL_MASK;
    ts_heat = w & ~y;
    ts_cool = y & ~w;
    fc_heat = fv & fob;
    fc_cool = fv & ~fob;

    sum_h = {1'b0, since_heat_r} + (TIMER_W+1)'(s1_item_r.elapsed_seconds);
    sum_c = {1'b0, since_cool_r} + (TIMER_W+1)'(s1_item_r.elapsed_seconds);
    sh = sum_h[TIMER_W] ? TIMER_MAX : sum_h[TIMER_W-1:0];
    sc = sum_c[TIMER_W] ? TIMER_MAX : sum_c[TIMER_W-1:0];

    heat = |(ts_heat | fc_heat);
    cool = |(ts_cool | fc_cool);
    mode = MODE_OFF;
    lock = 1'b0;

    if (s1_item_r.system_on) begin
      priority if (heat && cool) begin
        mode = (prev_mode_r == MODE_HEAT || prev_mode_r == MODE_COOL) ?
               prev_mode_r : MODE_STANDBY;
      end else if (heat) begin
        lock = (sc < sh) && (sc < c2h_lockout_r);
        mode = lock ? MODE_STANDBY : MODE_HEAT;
      end else if (cool) begin
        lock = (sh < sc) && (sh < h2c_lockout_r);
        mode = lock ? MODE_STANDBY : MODE_COOL;
      end else begin
        mode = MODE_STANDBY;
      end

      if (mode == MODE_HEAT) sh = '0;
      if (mode == MODE_COOL) sc = '0;

      if (mode == MODE_STANDBY) begin
        priority if (prev_mode_r == MODE_HEAT && sh < stby_delay_r) begin
          mode = MODE_HEAT;
        end else if (prev_mode_r == MODE_COOL && sc < stby_delay_r) begin
          mode = MODE_COOL;
        end else begin
          mode = MODE_STANDBY;
        end
      end
    end

    since_heat_nxt = sh;
    since_cool_nxt = sc;
    mode_nxt       = mode;

    out_item_nxt.pump_mode = mode;
    unique case (mode)
      MODE_HEAT: begin
        out_item_nxt.valve_targets = ts_heat;
        out_item_nxt.fancoil_pump  = |fc_heat;
      end
      MODE_COOL: begin
        out_item_nxt.valve_targets = ts_cool;
        out_item_nxt.fancoil_pump  = |fc_cool;
      end
      default: begin
        out_item_nxt.valve_targets = '0;
        out_item_nxt.fancoil_pump  = 1'b0;
      end
    endcase
    out_item_nxt.zone_pump = |out_item_nxt.valve_targets;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      since_heat_r <= TIMER_MAX;
      since_cool_r <= TIMER_MAX;
      prev_mode_r  <= MODE_OFF;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        since_heat_r <= since_heat_nxt;
        since_cool_r <= since_cool_nxt;
        prev_mode_r  <= mode_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_idle_pumps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.pump_mode == MODE_OFF ||
                    out_item_r.pump_mode == MODE_STANDBY)
    |-> (out_item_r.valve_targets == '0 && !out_item_r.fancoil_pump))
    else $error("pumps or valves active in off or standby");

  a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (prev_mode_r == out_item_r.pump_mode))
    else $error("previous mode differs from delivered mode");

  a_off_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !s1_item_r.system_on |=> prev_mode_r == MODE_OFF)
    else $error("system off did not force mode off");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire
